FILE: src/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg
// shared types and constants of the homogeneous line clipper
// ----------------------------------------------------------------------------
package hlc_pkg;
    localparam int FRAC_BITS = 16;
    localparam int T_W = FRAC_BITS + 1;
    localparam int PLANES = 6;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
endpackage

FILE: src/hlc_if.sv
// ----------------------------------------------------------------------------
// hlc_if
// valid/ready channel carrying one word of W bits
// ----------------------------------------------------------------------------
interface hlc_if #(parameter int W = 8) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/hlc_div.sv
// ----------------------------------------------------------------------------
// hlc_div
// pipelined restoring divider: q = min(floor(n * 2^16 / d), 1.0)
// one quotient bit per stage, n < d or clamp handled by saturation
// ----------------------------------------------------------------------------
module hlc_div #(
    parameter int NW = 34
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [NW-1:0]            i_num,
    input  logic [NW-1:0]            i_den,
    output logic [hlc_pkg::T_W-1:0]  o_q
);
    localparam int STG = hlc_pkg::T_W;
    localparam int RW = NW + 1;

    logic [RW-1:0]  r_rem [1:STG];
    logic [NW-1:0]  r_den [1:STG];
    logic [STG-1:0] r_q   [1:STG];
    logic           r_big [1:STG];

    for (genvar s = 0; s < STG; s++) begin : g_stage
        logic [RW-1:0]  n_rin;
        logic [NW-1:0]  n_din;
        logic [STG-1:0] n_qin;
        logic           n_bin;
        logic [RW-1:0]  n_rem;
        logic [RW:0]    n_sh;
        logic           n_bit;
        if (s == 0) begin : g_first
            assign n_rin = RW'(i_num);
            assign n_din = i_den;
            assign n_qin = '0;
            assign n_bin = (i_num >= i_den);
        end else begin : g_next
            assign n_rin = r_rem[s];
            assign n_din = r_den[s];
            assign n_qin = r_q[s];
            assign n_bin = r_big[s];
        end
        always_comb begin
            n_sh  = {n_rin, 1'b0};
            n_bit = (n_sh >= (RW+1)'(n_din));
            n_rem = n_sh[RW-1:0];
            if (n_bit) begin
                n_rem = RW'(n_sh - (RW+1)'(n_din));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_den[s+1] <= n_din;
                r_q[s+1]   <= {n_qin[STG-2:0], n_bit};
                r_big[s+1] <= n_bin;
            end
        end
    end

    // one extra quotient bit is formed, drop it for the 2^16 scale
    assign o_q = r_big[STG] ? hlc_pkg::T_ONE : {1'b0, r_q[STG][STG-1:1]};
endmodule

FILE: src/hlc_front.sv
// ----------------------------------------------------------------------------
// hlc_front
// boundary values, outcodes, and per-plane t by pipelined division
// ----------------------------------------------------------------------------
module hlc_front #(
    parameter int CW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [8*CW-1:0]        i_pts,
    output logic                   o_valid,
    output logic [8*CW-1:0]        o_pts,
    output logic                   o_accept,
    output logic                   o_reject,
    output logic [hlc_pkg::T_W-1:0] o_tin,
    output logic [hlc_pkg::T_W-1:0] o_tout
);
    localparam int BW = CW + 1;
    localparam int DW = CW + 2;
    localparam int P  = hlc_pkg::PLANES;
    localparam int TW = hlc_pkg::T_W;
    localparam int LAT = TW + 1;

    logic signed [BW-1:0] n_b0 [P];
    logic signed [BW-1:0] n_b1 [P];
    logic [P-1:0] n_oc0, n_oc1;

    always_comb begin
        for (int i = 0; i < P; i++) begin
            n_b0[i] = (i % 2 == 1)
                ? BW'($signed(i_pts[3*CW +: CW])) - BW'($signed(i_pts[(i/2)*CW +: CW]))
                : BW'($signed(i_pts[3*CW +: CW])) + BW'($signed(i_pts[(i/2)*CW +: CW]));
            n_b1[i] = (i % 2 == 1)
                ? BW'($signed(i_pts[7*CW +: CW])) - BW'($signed(i_pts[(4+i/2)*CW +: CW]))
                : BW'($signed(i_pts[7*CW +: CW])) + BW'($signed(i_pts[(4+i/2)*CW +: CW]));
            n_oc0[i] = n_b0[i][BW-1];
            n_oc1[i] = n_b1[i][BW-1];
        end
    end

    // stage 1 registers
    logic signed [BW-1:0] r_b0 [P];
    logic signed [BW-1:0] r_b1 [P];
    logic [P-1:0] r_oc0, r_oc1;
    logic [8*CW-1:0] r_pts [LAT+1];
    logic [P-1:0] r_act0 [1:LAT-1];
    logic [P-1:0] r_act1 [1:LAT-1];
    logic r_acc [1:LAT];
    logic r_rej [1:LAT];
    logic [LAT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < P; i++) begin
                r_b0[i] <= n_b0[i];
                r_b1[i] <= n_b1[i];
            end
            r_oc0 <= n_oc0;
            r_oc1 <= n_oc1;
            r_pts[0] <= i_pts;
        end
    end

    // stage 2: divisor setup, divider inputs
    logic [DW-1:0] n_num [P];
    logic [DW-1:0] n_den [P];
    logic [P-1:0]  n_zero;
    logic signed [DW-1:0] n_d [P];
    logic [TW-1:0] n_t [P];
    logic n_acc, n_rej;

    always_comb begin
        for (int i = 0; i < P; i++) begin
            n_d[i]   = DW'(r_b0[i]) - DW'(r_b1[i]);
            n_num[i] = r_b0[i][BW-1] ? DW'(-DW'(r_b0[i])) : DW'(r_b0[i]);
            n_den[i] = n_d[i][DW-1] ? DW'(-n_d[i]) : DW'(n_d[i]);
            n_zero[i] = (r_oc0[i] | r_oc1[i]) && (n_d[i] == '0);
        end
    end

    always_comb begin
        n_acc = ((r_oc0 | r_oc1) == '0);
        n_rej = ((r_oc0 & r_oc1) != '0) || (n_zero != '0);
    end

    for (genvar i = 0; i < P; i++) begin : g_div
        hlc_div #(.NW(DW)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (n_num[i]),
            .i_den ((n_den[i] == '0) ? DW'(1) : n_den[i]),
            .o_q   (n_t[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act0[1] <= r_oc0;
            r_act1[1] <= r_oc1;
            r_acc[1]  <= n_acc;
            r_rej[1]  <= n_rej;
            for (int s = 1; s < LAT-1; s++) begin
                r_act0[s+1] <= r_act0[s];
                r_act1[s+1] <= r_act1[s];
            end
            for (int s = 1; s < LAT; s++) begin
                r_acc[s+1]  <= r_acc[s];
                r_rej[s+1]  <= r_rej[s];
            end
            for (int s = 0; s < LAT; s++) begin
                r_pts[s+1] <= r_pts[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-1:0], i_valid};
        end
    end

    // stage after divider: min/max over six planes
    logic [TW-1:0] n_tin, n_tout;
    always_comb begin
        n_tin  = '0;
        n_tout = hlc_pkg::T_ONE;
        for (int i = 0; i < P; i++) begin
            if (r_act0[LAT-1][i] && n_t[i] > n_tin) begin
                n_tin = n_t[i];
            end
            if (r_act1[LAT-1][i] && n_t[i] < n_tout) begin
                n_tout = n_t[i];
            end
        end
    end

    logic [TW-1:0] r_tin, r_tout;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tin  <= n_tin;
            r_tout <= n_tout;
        end
    end

    assign o_valid  = r_vld[LAT];
    assign o_pts    = r_pts[LAT];
    assign o_accept = r_acc[LAT];
    assign o_reject = r_rej[LAT] || (r_tin > r_tout);
    assign o_tin    = r_tin;
    assign o_tout   = r_tout;
endmodule

FILE: src/hlc_back.sv
// ----------------------------------------------------------------------------
// hlc_back
// interpolation of both endpoints with rounding toward -inf and saturation
// ----------------------------------------------------------------------------
module hlc_back #(
    parameter int CW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hlc_if.sink                     s_in,
    hlc_if.source                   m_out
);
    localparam int TW = hlc_pkg::T_W;
    localparam int DW = CW + 1;
    localparam int PW = DW + TW + 1;
    localparam int SW = PW - hlc_pkg::FRAC_BITS + 1;
    // in word: {tout, tin, reject, accept, pts}
    localparam int PTS = 8*CW;
    localparam logic signed [SW-1:0] S_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic [PTS-1:0] w_pts;
    logic w_acc, w_rej;
    logic [TW-1:0] w_tin, w_tout;
    assign w_pts  = s_in.data[PTS-1:0];
    assign w_acc  = s_in.data[PTS];
    assign w_rej  = s_in.data[PTS+1];
    assign w_tin  = s_in.data[PTS+2 +: TW];
    assign w_tout = s_in.data[PTS+2+TW +: TW];

    logic r_v1, r_v2;
    logic en;
    assign en = !r_v2 || m_out.ready;
    assign s_in.ready = en;

    logic signed [PW-1:0] r_prod [8];
    logic signed [CW-1:0] r_a [8];
    logic r_acc1, r_rej1;
    logic [PTS-1:0] r_pts1;
    logic [PTS:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 8; k++) begin
                r_a[k] <= $signed(w_pts[(k%4)*CW +: CW]);
                r_prod[k] <= (PW'($signed(w_pts[(4+k%4)*CW +: CW]))
                    - PW'($signed(w_pts[(k%4)*CW +: CW])))
                    * $signed({1'b0, (k < 4) ? w_tin : w_tout});
            end
            r_acc1 <= w_acc;
            r_rej1 <= w_rej;
            r_pts1 <= w_pts;
        end
    end

    logic signed [SW-1:0] n_s [8];
    logic [PTS-1:0] n_res;
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_s[k] = SW'(r_a[k]) + SW'(r_prod[k] >>> hlc_pkg::FRAC_BITS);
            if (n_s[k] > S_MAX) begin
                n_res[k*CW +: CW] = {1'b0, {(CW-1){1'b1}}};
            end else if (n_s[k] < S_MIN) begin
                n_res[k*CW +: CW] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_res[k*CW +: CW] = n_s[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_acc1) begin
                r_out <= {1'b1, r_pts1};
            end else if (r_rej1) begin
                r_out <= '0;
            end else begin
                r_out <= {1'b1, n_res};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_in.valid;
            r_v2 <= r_v1;
        end
    end

    assign m_out.valid = r_v2;
    assign m_out.data  = r_out;
endmodule

FILE: src/hlc_fifo.sv
// ----------------------------------------------------------------------------
// hlc_fifo
// small word queue between front and back parts
// ----------------------------------------------------------------------------
module hlc_fifo #(
    parameter int W = 8,
    parameter int DEPTH_LOG = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hlc_if.sink     s_in,
    hlc_if.source   m_out,
    output logic [DEPTH_LOG:0] o_count
);
    localparam int DEPTH = 1 << DEPTH_LOG;
    logic [W-1:0] r_mem [DEPTH];
    logic [DEPTH_LOG:0] r_wp, r_rp;
    logic [DEPTH_LOG:0] w_mcnt;
    logic [W-1:0] r_dout;
    logic r_ov;
    logic wr, rd, pop;
    assign w_mcnt = r_wp - r_rp;
    assign o_count = w_mcnt + (DEPTH_LOG+1)'(r_ov);
    assign s_in.ready = (w_mcnt != (DEPTH_LOG+1)'(DEPTH));
    assign m_out.valid = r_ov;
    assign m_out.data = r_dout;
    assign wr = s_in.valid && s_in.ready;
    assign rd = r_ov && m_out.ready;
    // refill the output register when it is empty or being taken
    assign pop = (w_mcnt != '0) && (!r_ov || m_out.ready);
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp[DEPTH_LOG-1:0]] <= s_in.data;
        end
    end
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_dout <= r_mem[r_rp[DEPTH_LOG-1:0]];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_ov <= 1'b0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
                r_ov <= 1'b1;
            end else if (rd) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

FILE: src/homogeneous_line_clipper.sv
// ----------------------------------------------------------------------------
// homogeneous_line_clipper
// clips a homogeneous segment against -w <= x,y,z <= w
// ----------------------------------------------------------------------------
// input channel i_seg carries {end_w..end_x, start_w..start_x}, x lowest.
// output channel o_res carries {visible, clipped end w..x, clipped start w..x}.
// a front pipeline forms boundaries, outcodes and six t values through six
// 17-stage pipelined dividers, and each segment then passes to the queue. the
// queue holds 32 words plus one in its registered read output, and a two-stage
// interpolation back part drives the output register. one segment is taken
// per cycle while the receiver keeps up. the front advances only while
// queued words plus the up to 19 words in flight in the front stay below 32,
// so a stalled receiver fills the queue, then holds off the input, and no
// word is lost. rejected segments give visible 0 and zero fields; trivially
// accepted ones pass unchanged. reset empties the pipelines and the queue.
// ----------------------------------------------------------------------------
module homogeneous_line_clipper #(
    parameter int COORD_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hlc_if.sink   i_seg,
    hlc_if.source o_res
);
    localparam int CW = COORD_WIDTH;
    localparam int TW = hlc_pkg::T_W;
    localparam int QW = 8*CW + 2 + 2*TW;
    localparam int QL = 5;
    localparam int FLAT = TW + 2;

    hlc_if #(.W(QW)) q_in ();
    hlc_if #(.W(QW)) q_out ();

    logic [QL:0] w_cnt;
    logic [QL:0] r_fly;
    logic f_en;
    logic f_valid;
    logic [8*CW-1:0] f_pts;
    logic f_acc, f_rej;
    logic [TW-1:0] f_tin, f_tout;

    // words in flight in the front plus queued must fit
    assign f_en = (7'(w_cnt) + 7'(r_fly)) < 7'(1 << QL);
    assign i_seg.ready = f_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fly <= '0;
        end else if (f_en) begin
            r_fly <= r_fly + (QL+1)'(i_seg.valid) - (QL+1)'(f_valid);
        end
    end

    hlc_front #(.CW(CW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (f_en),
        .i_valid  (i_seg.valid),
        .i_pts    (i_seg.data),
        .o_valid  (f_valid),
        .o_pts    (f_pts),
        .o_accept (f_acc),
        .o_reject (f_rej),
        .o_tin    (f_tin),
        .o_tout   (f_tout)
    );

    assign q_in.valid = f_valid && f_en;
    assign q_in.data  = {f_tout, f_tin, f_rej, f_acc, f_pts};

    hlc_fifo #(.W(QW), .DEPTH_LOG(QL)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (q_in),
        .m_out   (q_out),
        .o_count (w_cnt)
    );

    hlc_back #(.CW(CW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (q_out),
        .m_out   (o_res)
    );

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_in.valid |-> q_in.ready)
        else $error("queue overflow");
    ap_fly_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fly <= (QL+1)'(FLAT))
        else $error("front occupancy out of range");
    ap_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data[8*CW]) |-> (o_res.data[8*CW-1:0] == '0))
        else $error("rejected word not zero");
endmodule
